/* rtl/xccd_pkg.sv */
// shared types and constants for the command deframer
`default_nettype none
package xccd_pkg;

    localparam int PACKET_LEN  = 8;
    localparam int PAYLOAD_LEN = PACKET_LEN - 2;
    localparam int POS_W       = $clog2(PACKET_LEN);
    localparam int IDX_W       = $clog2(PAYLOAD_LEN);

    typedef logic [7:0]        t_byte;
    typedef logic [POS_W-1:0]  t_pos;
    typedef logic signed [15:0] t_speed;

    localparam t_pos  POS_SEARCH   = t_pos'(0);
    localparam t_pos  POS_FIRST    = t_pos'(1);
    localparam t_pos  POS_CHECKSUM = t_pos'(PACKET_LEN - 1);
    localparam t_byte HEADER_RESET = 8'hAA;

    typedef struct packed {
        t_speed speed_one;
        t_speed speed_two;
        t_speed speed_three;
    } t_speeds;

    // framer to output stage
    typedef struct packed {
        logic    load;
        t_speeds speeds;
    } t_result;

endpackage
`default_nettype wire

/* rtl/xccd_if.sv */
// channel interfaces: received bytes, speed commands, header configuration
`default_nettype none
interface xccd_byte_if;
    import xccd_pkg::*;
    logic  valid;
    logic  ready;
    t_byte rx_byte;
    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface xccd_speed_if;
    import xccd_pkg::*;
    logic   valid;
    logic   ready;
    t_speed speed_one;
    t_speed speed_two;
    t_speed speed_three;
    modport source (output valid, output speed_one, output speed_two, output speed_three,
                    input ready);
    modport sink   (input valid, input speed_one, input speed_two, input speed_three,
                    output ready);
endinterface

interface xccd_cfg_if;
    import xccd_pkg::*;
    logic  valid;
    logic  ready;
    t_byte header_byte;
    modport source (output valid, output header_byte, input ready);
    modport sink   (input valid, input header_byte, output ready);
endinterface
`default_nettype wire

/* rtl/xccd_framer.sv */
// packet framing: header search, payload capture, running xor and checksum test
`default_nettype none
module xccd_framer
    import xccd_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_cfg_we,
    input  wire t_byte   i_cfg_header,
    input  wire          i_byte_valid,
    input  wire t_byte   i_byte,
    input  wire          i_out_free,
    output logic         o_consume,
    output t_result      o_result
);

    t_byte r_header;
    t_pos  r_pos;
    t_byte r_xor;
    t_byte r_payload [PAYLOAD_LEN];

    t_pos               n_pos;
    t_byte              n_xor;
    logic               is_chk;
    logic               emit;
    logic [IDX_W-1:0]   wr_idx;

    assign is_chk    = (r_pos == POS_CHECKSUM);
    assign emit      = i_byte_valid && is_chk && (i_byte == r_xor);
    assign o_consume = i_byte_valid && (!emit || i_out_free);
    assign wr_idx    = IDX_W'(r_pos - POS_FIRST);

    always_comb begin
        n_pos = r_pos;
        n_xor = r_xor;
        if (r_pos == POS_SEARCH) begin
            if (i_byte == r_header) begin
                n_pos = POS_FIRST;
                n_xor = i_byte;
            end
        end else if (is_chk) begin
            n_pos = POS_SEARCH;
            n_xor = '0;
        end else begin
            n_pos = r_pos + POS_FIRST;
            n_xor = r_xor ^ i_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header <= HEADER_RESET;
            r_pos    <= POS_SEARCH;
            r_xor    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_header <= i_cfg_header;
            end
            if (o_consume) begin
                r_pos <= n_pos;
                r_xor <= n_xor;
            end
        end
    end

    // payload store, written once per packet before the checksum byte
    always_ff @(posedge i_clk) begin
        if (o_consume && r_pos != POS_SEARCH && !is_chk) begin
            r_payload[wr_idx] <= i_byte;
        end
    end

    assign o_result.load               = emit && o_consume;
    assign o_result.speeds.speed_one   = $signed({r_payload[0], r_payload[1]});
    assign o_result.speeds.speed_two   = $signed({r_payload[2], r_payload[3]});
    assign o_result.speeds.speed_three = $signed({r_payload[4], r_payload[5]});

endmodule
`default_nettype wire

/* rtl/xccd_out_reg.sv */
// result register holding one speed command until the sink takes it
`default_nettype none
module xccd_out_reg
    import xccd_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire t_result i_result,
    input  wire          i_ready,
    output logic         o_free,
    output logic         o_valid,
    output t_speeds      o_speeds
);

    logic    r_valid;
    t_speeds r_speeds;

    assign o_free   = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_speeds = r_speeds;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_result.load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_result.load) begin
            r_speeds <= i_result.speeds;
        end
    end

endmodule
`default_nettype wire

/* rtl/xor_checked_command_deframer_unit.sv */
// top level of the xor checked command deframer
`default_nettype none
// Deframes motor command packets from a stream of received bytes. Each
// transaction on i_rx carries one byte. While searching, bytes are dropped
// until one equals the configured header byte (0xAA after reset). The next
// six bytes are the payload and the byte after that is an XOR checksum over
// header and payload. On a match, one transaction on o_cmd carries three
// big-endian signed 16-bit speeds; on a mismatch the packet is dropped
// silently. Either way search resumes with the next byte, and a header value
// seen inside a packet is treated as ordinary data. Throughput is one byte
// per clock: each byte lands in an input register, passes from there
// through the framing logic (8-bit compares and an xor), and a finished
// packet goes into a result register. A stalled sink stops the byte stream
// only when a new packet completes while the previous result is still
// waiting. The header byte is written through i_cfg, which is always ready
// outside reset; write it only while no packet is in flight.
module xor_checked_command_deframer_unit
    import xccd_pkg::*;
(
    input  wire           i_clk,
    input  wire           i_rst_n,
    xccd_byte_if.sink     i_rx,
    xccd_cfg_if.sink      i_cfg,
    xccd_speed_if.source  o_cmd
);

    // input register
    logic    r_in_valid;
    t_byte   r_in_byte;

    logic    consume;
    logic    out_free;
    logic    rx_take;
    t_result result;
    t_speeds out_speeds;

    // a byte enters when the register is empty or its byte moves on this cycle
    assign i_rx.ready = i_rst_n && (!r_in_valid || consume);
    assign rx_take    = i_rx.valid && i_rx.ready;
    assign i_cfg.ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (rx_take) begin
            r_in_valid <= 1'b1;
        end else if (consume) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rx_take) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    // header search, payload capture and checksum test
    xccd_framer u_framer (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg.valid && i_cfg.ready),
        .i_cfg_header (i_cfg.header_byte),
        .i_byte_valid (r_in_valid),
        .i_byte       (r_in_byte),
        .i_out_free   (out_free),
        .o_consume    (consume),
        .o_result     (result)
    );

    // result register toward the command sink
    xccd_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_result (result),
        .i_ready  (o_cmd.ready),
        .o_free   (out_free),
        .o_valid  (o_cmd.valid),
        .o_speeds (out_speeds)
    );

    assign o_cmd.speed_one   = out_speeds.speed_one;
    assign o_cmd.speed_two   = out_speeds.speed_two;
    assign o_cmd.speed_three = out_speeds.speed_three;

endmodule
`default_nettype wire

/* rtl/xccd_checker.sv */
// port level checks for the command deframer, bound to the top level
`default_nettype none
module xccd_checker
    import xccd_pkg::*;
(
    input wire         i_clk,
    input wire         i_rst_n,
    input wire         i_rx_valid,
    input wire         i_rx_ready,
    input wire         i_cmd_valid,
    input wire         i_cmd_ready,
    input wire t_speed i_speed_one,
    input wire t_speed i_speed_two,
    input wire t_speed i_speed_three
);

    // reset empties the result register
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_cmd_valid)
        else $error("command valid after reset");

    // a stalled command holds its speeds
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_valid && !i_cmd_ready |=> i_cmd_valid && $stable(i_speed_one)
            && $stable(i_speed_two) && $stable(i_speed_three))
        else $error("stalled command changed");

    // a new command follows the checksum byte taken on i_rx, through the input register and the result register
    a_cmd_from_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_cmd_valid) |-> $past(i_rx_valid && i_rx_ready, 2))
        else $error("command without a byte transaction");

endmodule

bind xor_checked_command_deframer_unit xccd_checker u_xccd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_rx_valid    (i_rx.valid),
    .i_rx_ready    (i_rx.ready),
    .i_cmd_valid   (o_cmd.valid),
    .i_cmd_ready   (o_cmd.ready),
    .i_speed_one   (o_cmd.speed_one),
    .i_speed_two   (o_cmd.speed_two),
    .i_speed_three (o_cmd.speed_three)
);
`default_nettype wire
